### design/global_sequence_aligner_top_defines.svh
// assertion macros shared by the checker
`ifndef GLOBAL_SEQUENCE_ALIGNER_TOP_DEFINES_SVH
`define GLOBAL_SEQUENCE_ALIGNER_TOP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define GSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// combinational invariant checked at every clock edge outside reset
`define GSA_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

### design/gsa_pkg.sv
package gsa_pkg;

   localparam int IDX_W     = 6;
   localparam int SCORE_W   = 32;
   localparam int EXT_W     = 36;
   localparam int RES_W     = 8;
   localparam int LET_W     = 5;
   localparam int ENTRY_W   = 12;
   localparam int GAP_W     = 16;
   localparam int TAB_AW    = 2 * LET_W;
   localparam int TAB_W     = ENTRY_W + 1;
   localparam int FRAC_BITS = 4;
   localparam int BLOSUM_N  = 20;

   localparam logic [LET_W-1:0] NO_LETTER = 5'd31;
   localparam logic [RES_W-1:0] CHAR_A    = 8'h41;
   localparam logic [RES_W-1:0] CHAR_Z    = 8'h5A;

   localparam logic CSR_GAP_OPEN   = 1'b0;
   localparam logic CSR_GAP_EXTEND = 1'b1;

   typedef enum logic [1:0] {
      ACT_APPEND_A = 2'd0,
      ACT_APPEND_B = 2'd1,
      ACT_TABLE    = 2'd2,
      ACT_ALIGN    = 2'd3
   } action_type;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_ALIGN_START,
      CMD_ROW0,
      CMD_ROW_START,
      CMD_CELL_RD,
      CMD_CELL_TB,
      CMD_CELL_WR,
      CMD_WALK_START,
      CMD_WALK_PUSH,
      CMD_WALK_NEXT,
      CMD_REPLAY_START,
      CMD_REPLAY_RD,
      CMD_REPLAY_SEG,
      CMD_EMIT,
      CMD_EMPTY,
      CMD_FINISH
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW0,
      ST_ROW_START,
      ST_CELL_RD,
      ST_CELL_TB,
      ST_CELL_WR,
      ST_WALK_START,
      ST_WALK_PUSH,
      ST_WALK_WAIT,
      ST_REPLAY_START,
      ST_REPLAY_RD,
      ST_REPLAY_SEG,
      ST_EMIT,
      ST_EMPTY,
      ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic clr_done;
      logic la_zero;
      logic lb_zero;
      logic col_last;
      logic row_last;
      logic at_origin;
      logic at_edge;
      logic seg_done;
      logic out_taken;
      logic out_last;
   } status_type;

   localparam int BLOSUM [BLOSUM_N][BLOSUM_N] = '{
      '{ 4, 0,-2,-1,-2, 0,-2,-1,-1,-1,-1,-2,-1,-1,-1, 1, 0, 0,-3,-2},
      '{ 0, 9,-3,-4,-2,-3,-3,-1,-3,-1,-1,-3,-3,-3,-3,-1,-1,-1,-2,-2},
      '{-2,-3, 6, 2,-3,-1,-1,-3,-1,-4,-3, 1,-1, 0,-2, 0,-1,-3,-4,-3},
      '{-1,-4, 2, 5,-3,-2, 0,-3, 1,-3,-2, 0,-1, 2, 0, 0,-1,-2,-3,-2},
      '{-2,-2,-3,-3, 6,-3,-1, 0,-3, 0, 0,-3,-4,-3,-3,-2,-2,-1, 1, 3},
      '{ 0,-3,-1,-2,-3, 6,-2,-4,-2,-4,-3, 0,-2,-2,-2, 0,-2,-3,-2,-3},
      '{-2,-3,-1, 0,-1,-2, 8,-3,-1,-3,-2, 1,-2, 0, 0,-1,-2,-3,-2, 2},
      '{-1,-1,-3,-3, 0,-4,-3, 4,-3, 2, 1,-3,-3,-3,-3,-2,-1, 3,-3,-1},
      '{-1,-3,-1, 1,-3,-2,-1,-3, 5,-2,-1, 0,-1, 1, 2, 0,-1,-2,-3,-2},
      '{-1,-1,-4,-3, 0,-4,-3, 2,-2, 4, 2,-3,-3,-2,-2,-2,-1, 1,-2,-1},
      '{-1,-1,-3,-2, 0,-3,-2, 1,-1, 2, 5,-2,-2, 0,-1,-1,-1, 1,-1,-1},
      '{-2,-3, 1, 0,-3, 0, 1,-3, 0,-3,-2, 6,-2, 0, 0, 1, 0,-3,-4,-2},
      '{-1,-3,-1,-1,-4,-2,-2,-3,-1,-3,-2,-2, 7,-1,-2,-1,-1,-2,-4,-3},
      '{-1,-3, 0, 2,-3,-2, 0,-3, 1,-2, 0, 0,-1, 5, 1, 0,-1,-2,-2,-1},
      '{-1,-3,-2, 0,-3,-2, 0,-3, 2,-2,-1, 0,-2, 1, 5,-1,-1,-3,-3,-2},
      '{ 1,-1, 0, 0,-2, 0,-1,-2, 0,-2,-1, 1,-1, 0,-1, 4, 1,-2,-3,-2},
      '{ 0,-1,-1,-1,-2,-2,-2,-1,-1,-1,-1, 0,-1,-1,-1, 1, 5, 0,-2,-2},
      '{ 0,-1,-3,-2,-1,-3,-3, 3,-2, 1, 1,-3,-2,-2,-3,-2, 0, 4,-3,-1},
      '{-3,-2,-4,-3, 1,-2,-2,-3,-3,-2,-1,-4,-4,-2,-3,-3,-2,-3,11, 2},
      '{-2,-2,-3,-2, 3,-3, 2,-1,-2,-1,-1,-2,-3,-1,-2,-2,-2,-1, 2, 7}
   };

   // letter 0..25 to its blosum row, NO_LETTER when the letter has none
   function automatic logic [LET_W-1:0] blosum_index(input logic [LET_W-1:0] letter);
      logic [LET_W-1:0] idx;
      unique case (letter)
         5'd0:    idx = 5'd0;
         5'd2:    idx = 5'd1;
         5'd3:    idx = 5'd2;
         5'd4:    idx = 5'd3;
         5'd5:    idx = 5'd4;
         5'd6:    idx = 5'd5;
         5'd7:    idx = 5'd6;
         5'd8:    idx = 5'd7;
         5'd10:   idx = 5'd8;
         5'd11:   idx = 5'd9;
         5'd12:   idx = 5'd10;
         5'd13:   idx = 5'd11;
         5'd15:   idx = 5'd12;
         5'd16:   idx = 5'd13;
         5'd17:   idx = 5'd14;
         5'd18:   idx = 5'd15;
         5'd19:   idx = 5'd16;
         5'd21:   idx = 5'd17;
         5'd22:   idx = 5'd18;
         5'd24:   idx = 5'd19;
         default: idx = NO_LETTER;
      endcase
      return idx;
   endfunction

   // substitution table contents after reset, scaled and saturated
   function automatic logic [TAB_W-1:0] table_reset_entry(input logic [TAB_AW-1:0] addr);
      logic [LET_W-1:0] ri;
      logic [LET_W-1:0] ci;
      int               v;
      logic [TAB_W-1:0] entry;
      ri = blosum_index(addr[TAB_AW-1:LET_W]);
      ci = blosum_index(addr[LET_W-1:0]);
      entry = '0;
      if ((ri != NO_LETTER) && (ci != NO_LETTER)) begin
         v = BLOSUM[ri][ci] * (1 << FRAC_BITS);
         if (v > 2047) begin
            v = 2047;
         end
         if (v < -2048) begin
            v = -2048;
         end
         entry = {1'b1, v[ENTRY_W-1:0]};
      end
      return entry;
   endfunction

endpackage

### design/gsa_ctrl.sv
module gsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_action,
   output logic                 req_ready,
   input  gsa_pkg::status_type  status,
   output gsa_pkg::cmd_type     cmd
);
   import gsa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd = CMD_CLEAR;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_ALIGN) begin
                  cmd = CMD_ALIGN_START;
                  if (status.la_zero && status.lb_zero) begin
                     state_in = ST_EMPTY;
                  end else begin
                     state_in = ST_ROW0;
                  end
               end else begin
                  cmd = CMD_LOAD;
               end
            end
         end
         ST_ROW0: begin
            cmd = CMD_ROW0;
            if (status.col_last) begin
               state_in = status.la_zero ? ST_WALK_START : ST_ROW_START;
            end
         end
         ST_ROW_START: begin
            cmd = CMD_ROW_START;
            if (!status.lb_zero) begin
               state_in = ST_CELL_RD;
            end else if (status.row_last) begin
               state_in = ST_WALK_START;
            end
         end
         ST_CELL_RD: begin
            cmd      = CMD_CELL_RD;
            state_in = ST_CELL_TB;
         end
         ST_CELL_TB: begin
            cmd      = CMD_CELL_TB;
            state_in = ST_CELL_WR;
         end
         ST_CELL_WR: begin
            cmd = CMD_CELL_WR;
            if (!status.col_last) begin
               state_in = ST_CELL_RD;
            end else if (status.row_last) begin
               state_in = ST_WALK_START;
            end else begin
               state_in = ST_ROW_START;
            end
         end
         ST_WALK_START: begin
            cmd      = CMD_WALK_START;
            state_in = ST_WALK_PUSH;
         end
         ST_WALK_PUSH: begin
            cmd = CMD_WALK_PUSH;
            if (status.at_origin) begin
               state_in = ST_REPLAY_START;
            end else if (!status.at_edge) begin
               state_in = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            cmd      = CMD_WALK_NEXT;
            state_in = ST_WALK_PUSH;
         end
         ST_REPLAY_START: begin
            cmd      = CMD_REPLAY_START;
            state_in = ST_REPLAY_RD;
         end
         ST_REPLAY_RD: begin
            cmd      = CMD_REPLAY_RD;
            state_in = ST_REPLAY_SEG;
         end
         ST_REPLAY_SEG: begin
            cmd      = CMD_REPLAY_SEG;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd      = CMD_EMIT;
            state_in = ST_OUT_WAIT;
         end
         ST_EMPTY: begin
            cmd      = CMD_EMPTY;
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (status.out_taken) begin
               if (status.out_last) begin
                  cmd      = CMD_FINISH;
                  state_in = ST_IDLE;
               end else if (status.seg_done) begin
                  state_in = ST_REPLAY_RD;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/gsa_dp.sv
module gsa_dp #(
   parameter int MAX_LEN = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gsa_pkg::cmd_type                      cmd,
   output gsa_pkg::status_type                   status,
   input  logic [1:0]                            req_action,
   input  logic [gsa_pkg::RES_W-1:0]             req_residue,
   input  logic [gsa_pkg::LET_W-1:0]             req_row_letter,
   input  logic [gsa_pkg::LET_W-1:0]             req_col_letter,
   input  logic signed [gsa_pkg::ENTRY_W-1:0]    req_entry_score,
   input  logic                                  req_entry_present,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [gsa_pkg::GAP_W-1:0]             csr_wdata,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_a,
   output logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_b,
   output logic signed [gsa_pkg::SCORE_W-1:0]    rsp_total_score,
   output logic                                  rsp_last,
   output logic                                  rsp_empty_alignment
);
   import gsa_pkg::*;

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int GW  = MAX_LEN + 1;
   localparam int TD  = GW * GW;
   localparam int TAW = $clog2(TD);
   localparam int CAW = $clog2(GW);
   localparam int PD  = 2 * MAX_LEN + 2;
   localparam int PW  = $clog2(PD);
   localparam int PCW = $clog2(PD + 1);
   localparam int CW  = SCORE_W + EXT_W + LW;

   // configuration
   logic signed [GAP_W-1:0] gap_open_ff;
   logic signed [GAP_W-1:0] gap_ext_ff;

   // sequence stores and lengths
   logic [RES_W-1:0] seq_a_mem [MAX_LEN];
   logic [RES_W-1:0] seq_b_mem [MAX_LEN];
   logic [RES_W-1:0] a_rd_ff;
   logic [RES_W-1:0] b_rd_ff;
   logic [LW-1:0]    len_a_ff;
   logic [LW-1:0]    len_b_ff;

   // substitution table
   logic [TAB_W-1:0]  table_mem [1 << TAB_AW];
   logic [TAB_W-1:0]  tab_rd_ff;
   logic [TAB_AW-1:0] clr_ff;
   logic              unk_ff;

   // one row of the score grid plus the vertical gap run per column
   logic [CW-1:0]     col_mem [GW];
   logic [CW-1:0]     col_rd_ff;
   logic [2*LW-1:0]   trace_mem [TD];
   logic [2*LW-1:0]   trace_rd_ff;
   logic [2*LW-1:0]   path_mem [PD];
   logic [2*LW-1:0]   path_rd_ff;

   // fill control
   logic [LW-1:0]              i_ff;
   logic [LW-1:0]              j_ff;
   logic signed [SCORE_W-1:0]  acc_ff;
   logic signed [SCORE_W-1:0]  bnd_ff;
   logic signed [SCORE_W-1:0]  diag_ff;
   logic signed [SCORE_W-1:0]  left_ff;
   logic signed [EXT_W-1:0]    f_ff;
   logic [LW-1:0]              fs_ff;
   logic signed [SCORE_W-1:0]  total_ff;

   // traceback
   logic [LW-1:0]  cur_i_ff;
   logic [LW-1:0]  cur_j_ff;
   logic [LW-1:0]  prev_i_ff;
   logic [LW-1:0]  prev_j_ff;
   logic [PCW-1:0] np_ff;
   logic [PCW-1:0] rp_ff;
   logic [LW-1:0]  k_ff;
   logic           seg_diag_ff;
   logic           seg_vert_ff;
   logic           end_ff;

   // output register
   logic                       rsp_valid_ff;
   logic signed [IDX_W-1:0]    rsp_index_a_ff;
   logic signed [IDX_W-1:0]    rsp_index_b_ff;
   logic signed [SCORE_W-1:0]  rsp_total_ff;
   logic                       rsp_last_ff;
   logic                       rsp_empty_ff;

   // cell arithmetic
   logic signed [SCORE_W-1:0] up_s;
   logic signed [EXT_W-1:0]   e_old;
   logic [LW-1:0]             es_old;
   logic signed [EXT_W-1:0]   op_w;
   logic signed [EXT_W-1:0]   ext_w;
   logic signed [EXT_W-1:0]   e_open;
   logic signed [EXT_W-1:0]   e_ext;
   logic signed [EXT_W-1:0]   e_new;
   logic [LW-1:0]             es_new;
   logic signed [EXT_W-1:0]   f_open;
   logic signed [EXT_W-1:0]   f_ext;
   logic signed [EXT_W-1:0]   f_new;
   logic [LW-1:0]             fs_new;
   logic signed [EXT_W-1:0]   pair_w;
   logic signed [EXT_W-1:0]   best;
   logic [LW-1:0]             tu;
   logic [LW-1:0]             tl;
   logic signed [SCORE_W-1:0] s_new;
   logic signed [SCORE_W-1:0] row0_s;
   logic signed [SCORE_W-1:0] bnd_new;

   logic                      a_ok;
   logic                      b_ok;
   logic [RES_W-1:0]          a_off;
   logic [RES_W-1:0]          b_off;
   logic [TAB_AW-1:0]         tab_raddr;
   logic [TAB_AW-1:0]         tab_waddr;
   logic [TAB_W-1:0]          tab_wdata;
   logic                      tab_we;

   logic [TAW-1:0]            cell_addr;
   logic [TAW-1:0]            walk_addr;
   logic [LW-1:0]             path_i;
   logic [LW-1:0]             path_j;
   logic                      fin;
   logic signed [IDX_W-1:0]   emit_a;
   logic signed [IDX_W-1:0]   emit_b;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff <= -16'sd176;
         gap_ext_ff  <= -16'sd16;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_OPEN:   gap_open_ff <= csr_wdata;
            CSR_GAP_EXTEND: gap_ext_ff  <= csr_wdata;
            default:        gap_open_ff <= gap_open_ff;
         endcase
      end
   end

   assign op_w  = EXT_W'(gap_open_ff);
   assign ext_w = EXT_W'(gap_ext_ff);

   // sequence loads
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD && req_action == ACT_APPEND_A && int'(len_a_ff) < MAX_LEN) begin
         seq_a_mem[SAW'(len_a_ff)] <= req_residue;
      end
      if (cmd == CMD_LOAD && req_action == ACT_APPEND_B && int'(len_b_ff) < MAX_LEN) begin
         seq_b_mem[SAW'(len_b_ff)] <= req_residue;
      end
      if (cmd == CMD_ROW_START) begin
         a_rd_ff <= seq_a_mem[SAW'(i_ff - 1'b1)];
      end
      if (cmd == CMD_CELL_RD) begin
         b_rd_ff <= seq_b_mem[SAW'(j_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
      end else if (cmd == CMD_FINISH) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
      end else if (cmd == CMD_LOAD) begin
         if (req_action == ACT_APPEND_A && int'(len_a_ff) < MAX_LEN) begin
            len_a_ff <= len_a_ff + 1'b1;
         end
         if (req_action == ACT_APPEND_B && int'(len_b_ff) < MAX_LEN) begin
            len_b_ff <= len_b_ff + 1'b1;
         end
      end
   end

   // substitution table: reset sweep and table writes share the port
   assign tab_we    = (cmd == CMD_CLEAR) ||
                      (cmd == CMD_LOAD && req_action == ACT_TABLE);
   assign tab_waddr = (cmd == CMD_CLEAR) ? clr_ff : {req_row_letter, req_col_letter};
   assign tab_wdata = (cmd == CMD_CLEAR) ? table_reset_entry(clr_ff) :
                      (req_entry_present ? {1'b1, req_entry_score} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd == CMD_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign a_off     = a_rd_ff - CHAR_A;
   assign b_off     = b_rd_ff - CHAR_A;
   assign a_ok      = (a_rd_ff >= CHAR_A) && (a_rd_ff <= CHAR_Z);
   assign b_ok      = (b_rd_ff >= CHAR_A) && (b_rd_ff <= CHAR_Z);
   assign tab_raddr = {a_off[LET_W-1:0], b_off[LET_W-1:0]};

   always_ff @(posedge clock) begin
      if (tab_we) begin
         table_mem[tab_waddr] <= tab_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_CELL_TB) begin
         tab_rd_ff <= table_mem[tab_raddr];
         unk_ff    <= !(a_ok && b_ok);
      end
   end

   // cell evaluation
   assign up_s   = col_rd_ff[CW-1 -: SCORE_W];
   assign e_old  = col_rd_ff[LW +: EXT_W];
   assign es_old = col_rd_ff[LW-1:0];
   assign e_open = EXT_W'(up_s) + op_w;
   assign e_ext  = e_old + ext_w;
   assign f_open = EXT_W'(left_ff) + op_w;
   assign f_ext  = f_ff + ext_w;
   assign pair_w = (unk_ff || !tab_rd_ff[TAB_W-1]) ? ext_w :
                   EXT_W'($signed(tab_rd_ff[ENTRY_W-1:0]));

   always_comb begin
      // a vertical run keeps its earliest start on a tie
      if (i_ff == LW'(1)) begin
         e_new  = e_open;
         es_new = '0;
      end else if (e_ext >= e_open) begin
         e_new  = e_ext;
         es_new = es_old;
      end else begin
         e_new  = e_open;
         es_new = i_ff - 1'b1;
      end
      if (j_ff == LW'(1)) begin
         f_new  = f_open;
         fs_new = '0;
      end else if (f_ext >= f_open) begin
         f_new  = f_ext;
         fs_new = fs_ff;
      end else begin
         f_new  = f_open;
         fs_new = j_ff - 1'b1;
      end
      // diagonal first, then vertical, then horizontal
      best = EXT_W'(diag_ff) + pair_w;
      tu   = i_ff - 1'b1;
      tl   = j_ff - 1'b1;
      if (e_new > best) begin
         best = e_new;
         tu   = es_new;
         tl   = j_ff;
      end
      if (f_new > best) begin
         best = f_new;
         tu   = i_ff;
         tl   = fs_new;
      end
   end

   assign s_new   = best[SCORE_W-1:0];
   assign row0_s  = (j_ff == '0) ? '0 : acc_ff;
   assign bnd_new = (i_ff == LW'(1)) ? SCORE_W'(gap_open_ff) : bnd_ff + SCORE_W'(gap_ext_ff);

   assign cell_addr = TAW'(int'(i_ff) * GW + int'(j_ff));
   assign walk_addr = TAW'(int'(cur_i_ff) * GW + int'(cur_j_ff));

   always_ff @(posedge clock) begin
      if (cmd == CMD_ROW0) begin
         col_mem[CAW'(j_ff)] <= {row0_s, {EXT_W{1'b0}}, {LW{1'b0}}};
      end else if (cmd == CMD_CELL_WR) begin
         col_mem[CAW'(j_ff)] <= {s_new, e_new, es_new};
      end
      if (cmd == CMD_CELL_RD) begin
         col_rd_ff <= col_mem[CAW'(j_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_CELL_WR) begin
         trace_mem[cell_addr] <= {tu, tl};
      end
      if (cmd == CMD_WALK_PUSH) begin
         trace_rd_ff <= trace_mem[walk_addr];
      end
   end

   // fill counters and running boundary scores
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         unique case (cmd)
            CMD_ALIGN_START: begin
               i_ff <= LW'(1);
               j_ff <= '0;
            end
            CMD_ROW0: begin
               j_ff <= j_ff + 1'b1;
            end
            CMD_ROW_START: begin
               j_ff <= LW'(1);
               if (len_b_ff == '0) begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            CMD_CELL_WR: begin
               if (j_ff == len_b_ff) begin
                  i_ff <= i_ff + 1'b1;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            default: begin
               i_ff <= i_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_ALIGN_START: begin
            bnd_ff <= '0;
         end
         CMD_ROW0: begin
            acc_ff <= (j_ff == '0) ? SCORE_W'(gap_open_ff) : acc_ff + SCORE_W'(gap_ext_ff);
            if (j_ff == len_b_ff) begin
               total_ff <= row0_s;
            end
         end
         CMD_ROW_START: begin
            diag_ff <= bnd_ff;
            left_ff <= bnd_new;
            bnd_ff  <= bnd_new;
            if (i_ff == len_a_ff) begin
               total_ff <= bnd_new;
            end
         end
         CMD_CELL_WR: begin
            diag_ff <= up_s;
            left_ff <= s_new;
            f_ff    <= f_new;
            fs_ff   <= fs_new;
            if (i_ff == len_a_ff && j_ff == len_b_ff) begin
               total_ff <= s_new;
            end
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   // traceback walk stores the path, replay runs it forward
   assign path_i = path_rd_ff[2*LW-1:LW];
   assign path_j = path_rd_ff[LW-1:0];

   always_ff @(posedge clock) begin
      if (cmd == CMD_WALK_PUSH) begin
         path_mem[PW'(np_ff)] <= {cur_i_ff, cur_j_ff};
      end
      if (cmd == CMD_REPLAY_RD) begin
         path_rd_ff <= path_mem[PW'(rp_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= '0;
         rp_ff <= '0;
      end else begin
         unique case (cmd)
            CMD_WALK_START:   np_ff <= '0;
            CMD_WALK_PUSH:    np_ff <= np_ff + 1'b1;
            CMD_REPLAY_START: rp_ff <= np_ff - 1'b1;
            CMD_REPLAY_RD:    rp_ff <= rp_ff - 1'b1;
            default:          np_ff <= np_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_WALK_START: begin
            cur_i_ff <= len_a_ff;
            cur_j_ff <= len_b_ff;
         end
         CMD_WALK_PUSH: begin
            // on the grid border the path goes straight to the origin
            if (cur_i_ff == '0 || cur_j_ff == '0) begin
               cur_i_ff <= '0;
               cur_j_ff <= '0;
            end
         end
         CMD_WALK_NEXT: begin
            cur_i_ff <= trace_rd_ff[2*LW-1:LW];
            cur_j_ff <= trace_rd_ff[LW-1:0];
         end
         CMD_REPLAY_START: begin
            cur_i_ff <= '0;
            cur_j_ff <= '0;
         end
         CMD_REPLAY_RD: begin
            prev_i_ff <= cur_i_ff;
            prev_j_ff <= cur_j_ff;
         end
         CMD_REPLAY_SEG: begin
            cur_i_ff    <= path_i;
            cur_j_ff    <= path_j;
            seg_diag_ff <= (path_i == prev_i_ff + 1'b1) && (path_j == prev_j_ff + 1'b1);
            seg_vert_ff <= path_i > prev_i_ff;
            k_ff        <= (path_i > prev_i_ff) ? prev_i_ff + 1'b1 : prev_j_ff + 1'b1;
         end
         CMD_EMIT: begin
            k_ff   <= k_ff + 1'b1;
            end_ff <= fin;
         end
         CMD_EMPTY: begin
            end_ff <= 1'b1;
         end
         default: begin
            k_ff <= k_ff;
         end
      endcase
   end

   always_comb begin
      if (seg_diag_ff) begin
         emit_a = IDX_W'(cur_i_ff) - 1'b1;
         emit_b = IDX_W'(cur_j_ff) - 1'b1;
         fin    = 1'b1;
      end else if (seg_vert_ff) begin
         emit_a = IDX_W'(k_ff) - 1'b1;
         emit_b = '1;
         fin    = (k_ff == cur_i_ff);
      end else begin
         emit_a = '1;
         emit_b = IDX_W'(k_ff) - 1'b1;
         fin    = (k_ff == cur_j_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == CMD_EMIT || cmd == CMD_EMPTY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_EMIT) begin
         rsp_index_a_ff <= emit_a;
         rsp_index_b_ff <= emit_b;
         rsp_total_ff   <= total_ff;
         rsp_last_ff    <= fin && (rp_ff == '0);
         rsp_empty_ff   <= 1'b0;
      end else if (cmd == CMD_EMPTY) begin
         rsp_index_a_ff <= '1;
         rsp_index_b_ff <= '1;
         rsp_total_ff   <= '0;
         rsp_last_ff    <= 1'b1;
         rsp_empty_ff   <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_index_a         = rsp_index_a_ff;
   assign rsp_index_b         = rsp_index_b_ff;
   assign rsp_total_score     = rsp_total_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_empty_alignment = rsp_empty_ff;

   assign status.clr_done  = (clr_ff == '1);
   assign status.la_zero   = (len_a_ff == '0);
   assign status.lb_zero   = (len_b_ff == '0);
   assign status.col_last  = (j_ff == len_b_ff);
   assign status.row_last  = (i_ff == len_a_ff);
   assign status.at_origin = (cur_i_ff == '0) && (cur_j_ff == '0);
   assign status.at_edge   = (cur_i_ff == '0) || (cur_j_ff == '0);
   assign status.seg_done  = end_ff;
   assign status.out_taken = rsp_valid_ff && rsp_ready;
   assign status.out_last  = rsp_last_ff;

endmodule

### design/global_sequence_aligner_top.sv
// global alignment of two residue sequences with affine gap cost. items with
// action append-a, append-b or table-write are taken one per cycle while the
// block is idle. an align item fills the score grid one cell at a time through
// a single shared evaluation unit (per cell: sequence and column read, table
// read, evaluate and write). the traceback then walks the stored pointers back
// to the origin, reading the trace memory for each step, and the forward replay
// delivers the results one path segment at a time, holding each result while
// the result side stalls. after reset the substitution table is loaded with its
// defaults in a sweep over all 1024 entries, one entry a cycle, during which no
// item is accepted.
module global_sequence_aligner_top #(
   parameter int MAX_LEN = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [gsa_pkg::RES_W-1:0]             req_residue,
   input  logic [gsa_pkg::LET_W-1:0]             req_row_letter,
   input  logic [gsa_pkg::LET_W-1:0]             req_col_letter,
   input  logic signed [gsa_pkg::ENTRY_W-1:0]    req_entry_score,
   input  logic                                  req_entry_present,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_a,
   output logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_b,
   output logic signed [gsa_pkg::SCORE_W-1:0]    rsp_total_score,
   output logic                                  rsp_last,
   output logic                                  rsp_empty_alignment,
   // gap cost registers
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [gsa_pkg::GAP_W-1:0]             csr_wdata
);
   import gsa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: table sweep, load decode, fill, walk and replay order
   gsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // storage, cell evaluation, traceback and the output register
   gsa_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_residue         (req_residue),
      .req_row_letter      (req_row_letter),
      .req_col_letter      (req_col_letter),
      .req_entry_score     (req_entry_score),
      .req_entry_present   (req_entry_present),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_index_a         (rsp_index_a),
      .rsp_index_b         (rsp_index_b),
      .rsp_total_score     (rsp_total_score),
      .rsp_last            (rsp_last),
      .rsp_empty_alignment (rsp_empty_alignment)
   );

endmodule

### design/gsa_checker.sv
`include "global_sequence_aligner_top_defines.svh"

module gsa_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_a,
   input logic signed [gsa_pkg::IDX_W-1:0]      rsp_index_b,
   input logic signed [gsa_pkg::SCORE_W-1:0]    rsp_total_score,
   input logic                                  rsp_last,
   input logic                                  rsp_empty_alignment
);

   // items are taken only when no alignment is in flight
   `GSA_ASSERT_NEVER(a_ready_while_busy, req_ready && rsp_valid, "item taken during emission")

   `GSA_ASSERT(a_empty_form, rsp_valid && rsp_empty_alignment |-> rsp_last && rsp_index_a == -6'sd1 && rsp_index_b == -6'sd1 && rsp_total_score == 0, "bad empty result")

   `GSA_ASSERT(a_run_ends, rsp_valid && rsp_ready && rsp_last |=> !rsp_valid, "result after last")

   `GSA_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_score), "stalled result changed")

endmodule

bind global_sequence_aligner_top gsa_checker u_gsa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_index_a         (rsp_index_a),
   .rsp_index_b         (rsp_index_b),
   .rsp_total_score     (rsp_total_score),
   .rsp_last            (rsp_last),
   .rsp_empty_alignment (rsp_empty_alignment)
);
